[rtl/core/tdcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdcf_pkg;

    localparam int unsigned STATE_W   = 6;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned ACTION_W  = 8;
    localparam int unsigned NUM_W     = 7;
    localparam int unsigned MKIND_W   = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 7;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_REINIT = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MATCH_EXACT = 2'd0,
        MATCH_LOWER = 2'd1,
        MATCH_UPPER = 2'd2,
        MATCH_ELSE  = 2'd3
    } t_match;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NO_TABLE  = 2'd2,
        ST_NO_ELSE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_STATE = 1'b0,
        REG_NUM_STATES = 1'b1
    } t_reg;

    function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = ((c >= 8'd97) && (c <= 8'd122)) ? c - 8'd32 : c;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/table_driven_char_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  tdata / tuser contents (lowest bit first)
// s        in         tuser: kind; tdata: entry_state, entry_slot, match_kind,
//                     match_char, entry_next, entry_action, symbol
// m        out        tdata: status, from_state, current_state, action_taken,
//                     chosen_slot, echo_symbol
// cfg      in         write enable, register index, write data
//
// load, reinit, unused-kind and no-table words go from accept straight to the result state
// a scanned symbol word first issues a transition memory read, then evaluates one transition
// memory entry per cycle from slot 0 until a slot hits or the last slot has been evaluated
// synchronous active-low reset clears the row-loaded bits and state, and sets the config registers
// the transition memory is not cleared; a result waiting on i_m_tready lets one more
// word in, whose result then holds the block in its result state until it leaves

module table_driven_char_fsm #(
    parameter int unsigned STATE_COUNT       = 64,
    parameter int unsigned ENTRIES_PER_STATE = 16,
    parameter int unsigned ACTION_ID_BITS    = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // entry_state, entry_slot, match_kind, match_char, entry_next, entry_action, symbol
    input  wire logic [tdcf_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // kind
    input  wire logic [tdcf_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // status, from_state, current_state, action_taken, chosen_slot, echo_symbol
    output logic [tdcf_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [tdcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tdcf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tdcf_pkg::*;

    localparam int unsigned ROWS      = (STATE_COUNT < 64) ? STATE_COUNT : 64;
    localparam int unsigned RB        = $clog2(ROWS);
    localparam int unsigned SB        = $clog2(ENTRIES_PER_STATE);
    localparam int unsigned MEM_DEPTH = ROWS * ENTRIES_PER_STATE;
    localparam int unsigned AW        = $clog2(MEM_DEPTH);
    localparam int unsigned EW        = MKIND_W + CHAR_W + STATE_W + ACTION_ID_BITS;
    localparam logic [SB-1:0] LAST_SLOT = SB'(ENTRIES_PER_STATE - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_fsm;

    t_fsm r_fsm;
    logic [STATE_W-1:0]  r_state;
    logic [STATE_W-1:0]  r_init;
    logic [NUM_W-1:0]    r_num;
    logic [ROWS-1:0]     r_row_loaded;

    logic [EW-1:0]       r_mem [MEM_DEPTH];
    logic [EW-1:0]       r_rd;
    logic                r_rd_vld;
    logic [AW-1:0]       r_base;
    logic [SB-1:0]       r_issue;
    logic [SB-1:0]       r_eval;
    logic [CHAR_W-1:0]   r_sym;

    logic [STATUS_W-1:0] r_res_status;
    logic [STATE_W-1:0]  r_res_from;
    logic [STATE_W-1:0]  r_res_cur;
    logic [ACTION_W-1:0] r_res_action;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [CHAR_W-1:0]   r_res_sym;

    logic                r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // input word fields
    t_kind               in_kind;
    logic [STATE_W-1:0]  in_st;
    logic [SLOT_W-1:0]   in_slot;
    logic [MKIND_W-1:0]  in_mkind;
    logic [CHAR_W-1:0]   in_char;
    logic [STATE_W-1:0]  in_next;
    logic [ACTION_W-1:0] in_action;
    logic [CHAR_W-1:0]   in_sym;

    assign in_kind   = t_kind'(i_s_tuser);
    assign in_st     = i_s_tdata[5:0];
    assign in_slot   = i_s_tdata[9:6];
    assign in_mkind  = i_s_tdata[11:10];
    assign in_char   = i_s_tdata[19:12];
    assign in_next   = i_s_tdata[25:20];
    assign in_action = i_s_tdata[33:26];
    assign in_sym    = i_s_tdata[41:34];

    logic               accept;
    logic               load_ok;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               row_ok;
    logic               out_free;

    assign o_s_tready = (r_fsm == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign load_ok    = (32'(in_st) < STATE_COUNT) && (32'(in_slot) < ENTRIES_PER_STATE);
    assign wr_addr    = AW'(32'(in_st) * ENTRIES_PER_STATE + 32'(in_slot));
    assign rd_addr    = r_base + AW'(r_issue);
    assign row_ok     = (32'(r_state) < STATE_COUNT) && r_row_loaded[r_state[RB-1:0]];
    assign out_free   = !r_out_vld || i_m_tready;

    // evaluated entry
    t_match             e_kind;
    logic [CHAR_W-1:0]  e_char;
    logic [STATE_W-1:0] e_next;
    logic [ACTION_W-1:0] e_action;
    logic               hit;

    assign e_kind   = t_match'(r_rd[MKIND_W-1:0]);
    assign e_char   = r_rd[MKIND_W +: CHAR_W];
    assign e_next   = r_rd[MKIND_W + CHAR_W +: STATE_W];
    assign e_action = ACTION_W'(r_rd[MKIND_W + CHAR_W + STATE_W +: ACTION_ID_BITS]);

    always_comb begin
        unique case (e_kind)
            MATCH_EXACT: hit = (r_sym == e_char);
            MATCH_LOWER: hit = (fold_lower(r_sym) == e_char);
            MATCH_UPPER: hit = (fold_upper(r_sym) == e_char);
            MATCH_ELSE:  hit = 1'b1;
        endcase
    end

    // transition memory
    always_ff @(posedge i_clk) begin
        if (accept && (in_kind == KIND_LOAD) && load_ok) begin
            r_mem[wr_addr] <= {ACTION_ID_BITS'(in_action), in_next, in_char, in_mkind};
        end
        r_rd <= r_mem[rd_addr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_num  <= NUM_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_INIT_STATE: r_init <= i_cfg_data[STATE_W-1:0];
                REG_NUM_STATES: r_num  <= i_cfg_data;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_state      <= '0;
            r_row_loaded <= '0;
            r_out_vld    <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            if ((r_fsm == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_res_status <= ST_OK;
                        r_res_from   <= r_state;
                        r_res_cur    <= r_state;
                        r_res_action <= '0;
                        r_res_slot   <= '0;
                        r_res_sym    <= '0;
                        r_sym        <= in_sym;
                        r_fsm        <= S_DONE;
                        unique case (in_kind)
                            KIND_LOAD: begin
                                if (load_ok) begin
                                    r_row_loaded[in_st[RB-1:0]] <= 1'b1;
                                end
                            end
                            KIND_REINIT: begin
                                r_state   <= r_init;
                                r_res_cur <= r_init;
                            end
                            KIND_SYMBOL: begin
                                r_res_sym <= in_sym;
                                if (row_ok) begin
                                    r_base   <= AW'(32'(r_state) * ENTRIES_PER_STATE);
                                    r_issue  <= '0;
                                    r_eval   <= '0;
                                    r_rd_vld <= 1'b0;
                                    r_fsm    <= S_SCAN;
                                end else begin
                                    r_res_status <= ST_NO_TABLE;
                                end
                            end
                            KIND_NOP: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_issue  <= (r_issue == LAST_SLOT) ? '0 : r_issue + 1'b1;
                    r_rd_vld <= 1'b1;
                    if (r_rd_vld) begin
                        if (hit) begin
                            r_res_action <= e_action;
                            r_res_slot   <= SLOT_W'(r_eval);
                            if (NUM_W'(e_next) >= r_num) begin
                                r_res_status <= ST_RANGE;
                            end else begin
                                r_state   <= e_next;
                                r_res_cur <= e_next;
                            end
                            r_fsm <= S_DONE;
                        end else if (r_eval == LAST_SLOT) begin
                            r_res_status <= ST_NO_ELSE;
                            r_fsm        <= S_DONE;
                        end else begin
                            r_eval <= r_eval + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data <= {6'd0, r_res_sym, r_res_slot, r_res_action,
                                       r_res_cur, r_res_from, r_res_status};
                        r_fsm      <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

[bench/char_fsm_checker.sv]
`timescale 1ns / 1ps

module char_fsm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // entry_state, entry_slot, match_kind, match_char, entry_next, entry_action, symbol
    input  logic [tdcf_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // kind
    input  logic [tdcf_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // status, from_state, current_state, action_taken, chosen_slot, echo_symbol
    input  logic [tdcf_pkg::OUT_TDATA_W-1:0]    i_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [tdcf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tdcf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import tdcf_pkg::*;

    localparam int ROWS  = 64;
    localparam int SLOTS = 16;

    typedef struct packed {
        t_match                mkind;
        logic [CHAR_W-1:0]     chr;
        logic [STATE_W-1:0]    nxt;
        logic [ACTION_W-1:0]   act;
    } t_entry;

    typedef struct packed {
        t_status               status;
        logic [STATE_W-1:0]    from_state;
        logic [STATE_W-1:0]    current_state;
        logic [ACTION_W-1:0]   action_taken;
        logic [SLOT_W-1:0]     chosen_slot;
        logic [CHAR_W-1:0]     echo_symbol;
    } t_fsm_result;

    t_entry             trans_mem [ROWS][SLOTS];
    bit                 row_loaded [ROWS];
    logic [STATE_W-1:0] fsm_state;
    logic [STATE_W-1:0] init_reg;
    logic [NUM_W-1:0]   num_reg;
    t_fsm_result        expected_results [$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_fsm_result predict_step(input t_kind kind,
                                                 input logic [IN_TDATA_W-1:0] d);
        t_fsm_result        r;
        logic [STATE_W-1:0] st;
        logic [SLOT_W-1:0]  sl;
        logic [CHAR_W-1:0]  sym;
        logic [CHAR_W-1:0]  sym_lo;
        logic [CHAR_W-1:0]  sym_up;
        logic               hit;
        logic               found;
        t_entry             e;
        int                 i;
        r.status        = ST_OK;
        r.from_state    = fsm_state;
        r.action_taken  = '0;
        r.chosen_slot   = '0;
        r.echo_symbol   = '0;
        case (kind)
            KIND_LOAD: begin
                st = d[5:0];
                sl = d[9:6];
                trans_mem[st][sl].mkind = t_match'(d[11:10]);
                trans_mem[st][sl].chr   = d[19:12];
                trans_mem[st][sl].nxt   = d[25:20];
                trans_mem[st][sl].act   = d[33:26];
                row_loaded[st] = 1'b1;
            end
            KIND_REINIT: begin
                fsm_state = init_reg;
            end
            KIND_SYMBOL: begin
                sym = d[41:34];
                r.echo_symbol = sym;
                // only ascii letters fold
                sym_lo = (sym >= 8'h41 && sym <= 8'h5A) ? (sym | 8'h20) : sym;
                sym_up = (sym >= 8'h61 && sym <= 8'h7A) ? (sym & 8'hDF) : sym;
                if (!row_loaded[fsm_state]) begin
                    r.status = ST_NO_TABLE;
                end else begin
                    found = 1'b0;
                    for (i = 0; i < SLOTS && !found; i++) begin
                        e = trans_mem[fsm_state][i];
                        case (e.mkind)
                            MATCH_EXACT: hit = (sym == e.chr);
                            MATCH_LOWER: hit = (sym_lo == e.chr);
                            MATCH_UPPER: hit = (sym_up == e.chr);
                            default:     hit = 1'b1;
                        endcase
                        if (hit) begin
                            found = 1'b1;
                            r.action_taken = e.act;
                            r.chosen_slot  = i[SLOT_W-1:0];
                            if ({1'b0, e.nxt} >= num_reg) begin
                                r.status = ST_RANGE;
                            end else begin
                                fsm_state = e.nxt;
                            end
                        end
                    end
                    if (!found) begin
                        r.status = ST_NO_ELSE;
                    end
                end
            end
            default: ;
        endcase
        r.current_state = fsm_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fsm_result want;
        int          i;
        if (!i_rst_n) begin
            for (i = 0; i < ROWS; i++) begin
                row_loaded[i] = 1'b0;
            end
            init_reg  = '0;
            num_reg   = 7'd64;
            fsm_state = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", i_m_tdata);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_m_tdata[1:0]);
                    check_field("from_state", want.from_state, i_m_tdata[7:2]);
                    check_field("current_state", want.current_state, i_m_tdata[13:8]);
                    check_field("action_taken", want.action_taken, i_m_tdata[21:14]);
                    check_field("chosen_slot", want.chosen_slot, i_m_tdata[25:22]);
                    check_field("echo_symbol", want.echo_symbol, i_m_tdata[33:26]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_step(t_kind'(i_s_tuser), i_s_tdata));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_INIT_STATE) begin
                    init_reg = i_cfg_data[STATE_W-1:0];
                end else begin
                    num_reg = i_cfg_data;
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import tdcf_pkg::*;

    localparam int ROWS         = 64;
    localparam int SLOTS        = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 228;
    localparam int DRAIN_CYCLES = 24;
    localparam int RUN_LIMIT    = 400000;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // entry_state, entry_slot, match_kind, match_char, entry_next, entry_action, symbol
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    // kind
    logic [IN_TUSER_W-1:0]   s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b1;
    // status, from_state, current_state, action_taken, chosen_slot, echo_symbol
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int          fail_count;
    int          pending;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          words_sent = 0;
    int unsigned cycle_count = 0;

    // slots the generator has written, so a scan never reaches an unwritten slot
    bit slot_written [ROWS][SLOTS];
    bit slot_else    [ROWS][SLOTS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    table_driven_char_fsm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    char_fsm_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] entry_word(
        input logic [5:0] st, input logic [3:0] sl, input t_match mk,
        input logic [7:0] ch, input logic [5:0] nx, input logic [7:0] act,
        input logic [7:0] sym);
        return {6'b0, sym, act, nx, ch, mk, sl, st};
    endfunction

    // random bytes, or letters, their neighbours and the byte extremes
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        if ($urandom_range(9) < 4) begin
            return 8'($urandom_range(255));
        end
        case ($urandom_range(11))
            0:       c = 8'h40;
            1:       c = 8'h41;
            2:       c = 8'h5A;
            3:       c = 8'h5B;
            4:       c = 8'h60;
            5:       c = 8'h61;
            6:       c = 8'h7A;
            7:       c = 8'h7B;
            8:       c = 8'h4D;
            9:       c = 8'h6D;
            10:      c = 8'h00;
            default: c = 8'hFF;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] pick_state();
        return 6'(($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(63));
    endfunction

    function automatic logic [5:0] pick_next();
        return 6'(($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(63));
    endfunction

    function automatic bit load_keeps_safe(input int st, input int sl, input bit as_else);
        bit w [SLOTS];
        bit e [SLOTS];
        int i;
        for (i = 0; i < SLOTS; i++) begin
            w[i] = slot_written[st][i];
            e[i] = slot_else[st][i];
        end
        w[sl] = 1'b1;
        e[sl] = as_else;
        for (i = 0; i < SLOTS; i++) begin
            if (!w[i]) return 1'b0;
            if (e[i]) return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic send_word(input t_kind kind, input logic [IN_TDATA_W-1:0] data);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic load_entry(input logic [5:0] st, input logic [3:0] sl, input t_match mk,
                              input logic [7:0] ch, input logic [5:0] nx,
                              input logic [7:0] act);
        slot_written[st][sl] = 1'b1;
        slot_else[st][sl]    = (mk == MATCH_ELSE);
        send_word(KIND_LOAD, entry_word(st, sl, mk, ch, nx, act, 8'($urandom_range(255))));
    endtask

    // symbol, reinit and unused-kind words carry random entry fields
    task automatic send_plain(input t_kind kind, input logic [7:0] sym);
        send_word(kind, entry_word(6'($urandom_range(63)), 4'($urandom_range(15)),
                                   t_match'($urandom_range(3)), 8'($urandom_range(255)),
                                   6'($urandom_range(63)), 8'($urandom_range(255)), sym));
    endtask

    // a row always ends in an else entry or fills all slots
    task automatic build_row(input logic [5:0] st);
        int     len;
        int     i;
        int     r;
        bit     no_else;
        t_match mk;
        r = $urandom_range(9);
        if (r < 6) begin
            len = $urandom_range(1, 6);
        end else if (r < 9) begin
            len = $urandom_range(7, 15);
        end else begin
            len = SLOTS;
        end
        no_else = (len == SLOTS) && $urandom_range(1);
        for (i = 0; i < len; i++) begin
            if (i == len - 1 && !no_else) begin
                mk = MATCH_ELSE;
            end else if (!no_else && $urandom_range(9) == 0) begin
                mk = MATCH_ELSE;
            end else begin
                mk = t_match'($urandom_range(2));
            end
            load_entry(st, i[3:0], mk, pick_char(), pick_next(), 8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_regs(input logic [5:0] init_v, input logic [6:0] num_v);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_INIT_STATE;
        cfg_data <= {1'b0, init_v};
        @(posedge i_clk);
        cfg_idx  <= REG_NUM_STATES;
        cfg_data <= num_v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        int         phase;
        int         i;
        int         r;
        int         phase_end;
        bit         paused;
        logic [5:0] st;
        logic [3:0] sl;
        logic [5:0] init_v;
        logic [6:0] num_v;
        t_match     mk;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        send_plain(KIND_SYMBOL, 8'hFF);
        send_plain(KIND_NOP, 8'h00);
        load_entry(6'd0, 4'd0, MATCH_EXACT, 8'h61, 6'd1, 8'hFF);
        load_entry(6'd0, 4'd1, MATCH_LOWER, 8'h62, 6'd63, 8'h01);
        load_entry(6'd0, 4'd2, MATCH_UPPER, 8'h5A, 6'd2, 8'h80);
        load_entry(6'd0, 4'd3, MATCH_ELSE, 8'h00, 6'd0, 8'h55);
        send_plain(KIND_SYMBOL, 8'h61);
        send_plain(KIND_REINIT, 8'h00);
        send_plain(KIND_SYMBOL, 8'h42);
        for (i = 0; i < SLOTS; i++) begin
            load_entry(6'd63, i[3:0], MATCH_EXACT, 8'h80 + i[7:0], 6'd0, 8'hF0 | i[7:0]);
        end
        send_plain(KIND_SYMBOL, 8'h00);
        send_plain(KIND_SYMBOL, 8'h8F);
        send_plain(KIND_SYMBOL, 8'h7B);
        send_plain(KIND_SYMBOL, 8'h7A);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       begin init_v = 6'd0;  num_v = 7'd64; end
                1:       begin init_v = 6'd63; num_v = 7'd1;  end
                2:       begin init_v = 6'd3;  num_v = 7'd8;  end
                3:       begin init_v = 6'd63; num_v = 7'd64; end
                4:       begin
                    init_v = 6'($urandom_range(63));
                    num_v  = 7'($urandom_range(1, 64));
                end
                5:       begin init_v = 6'd0;  num_v = 7'd1;  end
                6:       begin init_v = 6'd7;  num_v = 7'd5;  end
                default: begin init_v = 6'd1;  num_v = 7'd64; end
            endcase
            write_regs(init_v, num_v);
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            if (phase == 0) begin
                for (i = 0; i < 8; i++) begin
                    build_row(i[5:0]);
                end
            end
            phase_end = words_sent + PHASE_WORDS;
            paused = 1'b0;
            while (words_sent < phase_end) begin
                if (!paused && words_sent >= phase_end - PHASE_WORDS / 2) begin
                    // sender holds off until every result is back
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(99);
                if (r < 6) begin
                    build_row(pick_state());
                end else if (r < 18) begin
                    st = pick_state();
                    sl = 4'($urandom_range(15));
                    mk = t_match'($urandom_range(3));
                    if (load_keeps_safe(int'(st), int'(sl), mk == MATCH_ELSE)) begin
                        load_entry(st, sl, mk, pick_char(), pick_next(),
                                   8'($urandom_range(255)));
                    end else begin
                        build_row(st);
                    end
                end else if (r < 26) begin
                    send_plain(KIND_REINIT, 8'($urandom_range(255)));
                end else if (r < 29) begin
                    send_plain(KIND_NOP, 8'($urandom_range(255)));
                end else begin
                    send_plain(KIND_SYMBOL, pick_char());
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
